// File: design/mmn_pkg.sv
// shared types and constants for the min-max normaliser
// no dependencies; imported by min_max_normalize and mmn_checker
`default_nettype none

package mmn_pkg;

	// parameter defaults
	localparam int DEPTH_DEF        = 64;
	localparam int SAMPLE_WIDTH_DEF = 16;

	// fixed widths of the q8.8 target registers and the result
	localparam int DATA_W    = 16;
	localparam int RANGE_W   = DATA_W + 1;
	localparam int QUO_W     = DATA_W + 1;
	localparam int DIV_CNT_W = $clog2(QUO_W);

	// target range used when both targets are equal: 0 .. 1.0
	localparam logic signed [DATA_W-1:0] ZERO_Q88 = DATA_W'(0);
	localparam logic signed [DATA_W-1:0] ONE_Q88  = DATA_W'(256);

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LOW  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HIGH = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_PREP,
		ST_DIV,
		ST_OUT
	} mmn_state_t;

endpackage

`default_nettype wire

// File: design/min_max_normalize.sv
// min-max normaliser: sample store, running min/max, shared multiply and restoring divider
// depends on mmn_pkg
`default_nettype none

// usage
//  input: a sample beat is taken on a rising edge with start high and busy low.
//  while a block fills, one sample is taken every cycle; the sample flagged
//  last_in, or the one that fills the store, closes the block and raises busy
//  output: each stored sample comes back in arrival order on scaled for exactly
//  one cycle with result_strobe high; last_out marks the final beat of the block.
//  the receiver cannot stall, so results are never held back
//  timing: each result goes through store read, multiply, sign split,
//  17 divider steps and output, one result at a time through the single
//  restoring divider that is shared by all results. busy stays high until
//  the whole block is out; busy falls in the cycle after the last result
//  configuration: cfg_ready is always high; index 0 is target_low and index 1
//  target_high. write only while busy is low
//  reset: block empty, running min/max at their extremes, targets 0 and 1.0;
//  the sample store needs no clearing since only entries of the current
//  block are read
module min_max_normalize
	import mmn_pkg::*;
#(
	parameter int DEPTH        = DEPTH_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	// sample channel
	input  wire                           start,
	output logic                          busy,
	input  wire signed [SAMPLE_WIDTH-1:0] sample,
	input  wire                           last_in,
	// result channel
	output logic                          result_strobe,
	output logic signed [DATA_W-1:0]      scaled,
	output logic                          last_out,
	// configuration channel
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire [CFG_IDX_W-1:0]           cfg_index,
	input  wire [DATA_W-1:0]              cfg_data
);

	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DIFF_W = SAMPLE_WIDTH + 1;          // v - min and max - min, never negative
	localparam int PROD_W = DIFF_W + 1 + RANGE_W;      // signed product
	localparam int MAG_W  = DIFF_W + QUO_W - 1;        // product magnitude
	localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	mmn_state_t state_q, state_d;

	logic signed [DATA_W-1:0]       tlow_q, thigh_q;
	logic [SAMPLE_WIDTH-1:0]        mem [DEPTH];
	logic signed [SAMPLE_WIDTH-1:0] rd_q;
	logic signed [SAMPLE_WIDTH-1:0] min_q, max_q;
	logic [CNT_W-1:0]               cnt_q;
	logic [IDX_W-1:0]               idx_q;
	logic signed [PROD_W-1:0]       prod_q;
	logic [DIFF_W-1:0]              rem_q;
	logic [QUO_W-1:0]               quo_q;
	logic                           neg_q;
	logic [DIV_CNT_W-1:0]           div_cnt_q;

	logic                           accept;
	logic [CNT_W-1:0]               cnt_inc;
	logic                           close;
	logic                           last_idx;
	logic signed [DATA_W-1:0]       tl_eff, th_eff;
	logic signed [RANGE_W-1:0]      range_w;
	logic [DIFF_W-1:0]              diff_w, span_w;
	logic signed [PROD_W-1:0]       prod_w, prod_abs;
	logic [DIFF_W:0]                trial;
	logic                           trial_ge;
	logic signed [RANGE_W-1:0]      mid_sum, quo_signed, res_sum;
	logic                           div_done;

	// handshake and block bookkeeping
	assign accept   = start && !busy;
	assign cnt_inc  = cnt_q + CNT_W'(1);
	assign close    = last_in || (cnt_inc == CNT_W'(DEPTH));
	assign last_idx = ((CNT_W'(idx_q) + CNT_W'(1)) == cnt_q);
	assign div_done = (div_cnt_q == DIV_CNT_W'(QUO_W - 1));

	// equal targets fall back to 0 .. 1.0
	assign tl_eff  = (tlow_q == thigh_q) ? ZERO_Q88 : tlow_q;
	assign th_eff  = (tlow_q == thigh_q) ? ONE_Q88  : thigh_q;
	assign range_w = {th_eff[DATA_W-1], th_eff} - {tl_eff[DATA_W-1], tl_eff};

	// shared datapath: subtract, multiply, then one divider step a cycle
	assign diff_w   = {rd_q[SAMPLE_WIDTH-1], rd_q} - {min_q[SAMPLE_WIDTH-1], min_q};
	assign span_w   = {max_q[SAMPLE_WIDTH-1], max_q} - {min_q[SAMPLE_WIDTH-1], min_q};
	assign prod_w   = $signed({1'b0, diff_w}) * range_w;
	assign prod_abs = prod_q[PROD_W-1] ? -prod_q : prod_q;
	assign trial    = {rem_q, quo_q[QUO_W-1]};
	assign trial_ge = (trial >= {1'b0, span_w});

	// result assembly; quotient is at most 65535 so it fits signed 17 bits
	assign mid_sum    = {tlow_q[DATA_W-1], tlow_q} + {thigh_q[DATA_W-1], thigh_q};
	assign quo_signed = neg_q ? -$signed(quo_q) : $signed(quo_q);
	assign res_sum    = {tl_eff[DATA_W-1], tl_eff} + quo_signed;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlow_q  <= ZERO_Q88;
			thigh_q <= ONE_Q88;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TARGET_LOW:  tlow_q  <= $signed(cfg_data);
				CFG_TARGET_HIGH: thigh_q <= $signed(cfg_data);
			endcase
		end
	end

	// sample store, registered read at the emit index
	always_ff @(posedge clk) begin
		if (accept) begin
			mem[cnt_q[IDX_W-1:0]] <= sample;
		end
		rd_q <= $signed(mem[idx_q]);
	end

	// control state: fill count, running extremes, emit index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			idx_q     <= '0;
			min_q     <= S_MAX;
			max_q     <= S_MIN;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= cnt_inc;
				idx_q <= '0;
				if (sample < min_q) begin
					min_q <= sample;
				end
				if (sample > max_q) begin
					max_q <= sample;
				end
			end
			if (state_q == ST_PREP) begin
				div_cnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end
			if (state_q == ST_OUT) begin
				if (last_idx) begin
					// block done, back to an empty block
					cnt_q <= '0;
					min_q <= S_MAX;
					max_q <= S_MIN;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
		end
	end

	// multiplier and divider registers
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			prod_q <= prod_w;
		end
		if (state_q == ST_PREP) begin
			// top part is below the span because the quotient fits QUO_W bits
			neg_q <= prod_q[PROD_W-1];
			rem_q <= DIFF_W'(prod_abs[MAG_W-1:QUO_W]);
			quo_q <= prod_abs[QUO_W-1:0];
		end else if (state_q == ST_DIV) begin
			rem_q <= trial_ge ? DIFF_W'(trial - {1'b0, span_w}) : trial[DIFF_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], trial_ge};
		end
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && close) begin
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_MUL;
			ST_MUL:  state_d = ST_PREP;
			ST_PREP: state_d = ST_DIV;
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				state_d = last_idx ? ST_IDLE : ST_READ;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy          = 1'b1;
		result_strobe = 1'b0;
		last_out      = 1'b0;
		scaled        = res_sum[DATA_W-1:0];
		unique case (state_q)
			ST_IDLE: busy = 1'b0;
			ST_OUT: begin
				result_strobe = 1'b1;
				last_out      = last_idx;
				// flat block: floor of the midpoint of the written targets
				if (span_w == '0) begin
					scaled = mid_sum[RANGE_W-1:1];
				end
			end
			default: busy = 1'b1;
		endcase
	end

endmodule

`default_nettype wire

// File: design/mmn_checker.sv
// port-level checks for min_max_normalize, bound into every min_max_normalize instance
// depends on min_max_normalize's ports only
`default_nettype none

module mmn_port_checks (
	input wire clk,
	input wire arst_n,
	input wire start,
	input wire busy,
	input wire result_strobe,
	input wire last_out
);

	// results only appear while a block is being emitted
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> busy)
		else $error("result beat while not busy");

	// each result needs the full divider pass, so beats never touch
	a_strobe_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |=> !result_strobe)
		else $error("back-to-back result beats");

	// the final beat of a block releases the sample channel
	a_last_release: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && last_out |=> !busy)
		else $error("busy held after last result beat");

	// a sample beat is never followed at once by a result
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !result_strobe)
		else $error("result beat straight after a sample beat");

	// last_out only ever rides on a result beat
	a_last_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last_out |-> result_strobe)
		else $error("last_out without a result beat");

endmodule

bind min_max_normalize mmn_port_checks u_mmn_port_checks (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.result_strobe (result_strobe),
	.last_out      (last_out)
);

`default_nettype wire

// File: verif/mmn_checker.sv
`timescale 1ns / 100ps
// checker for the min-max normaliser: watches the sample, result and config channels
// and predicts every rescaled beat; depends on mmn_pkg
module mmn_checker
	import mmn_pkg::*;
(
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	input  wire                               busy,
	input  wire signed [SAMPLE_WIDTH_DEF-1:0] sample,
	input  wire                               last_in,
	input  wire                               result_strobe,
	input  wire signed [DATA_W-1:0]           scaled,
	input  wire                               last_out,
	input  wire                               cfg_valid,
	input  wire                               cfg_ready,
	input  wire [CFG_IDX_W-1:0]               cfg_index,
	input  wire [DATA_W-1:0]                  cfg_data,
	output int                                mismatches,
	output int                                pending
);

	localparam logic signed [SAMPLE_WIDTH_DEF-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH_DEF-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH_DEF-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH_DEF-1){1'b0}}};

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} norm_beat_t;

	norm_beat_t                         scaled_due[$];
	norm_beat_t                         head;
	logic signed [DATA_W-1:0]           tgt_low;
	logic signed [DATA_W-1:0]           tgt_high;
	logic signed [SAMPLE_WIDTH_DEF-1:0] held [DEPTH_DEF];
	logic signed [SAMPLE_WIDTH_DEF-1:0] run_min;
	logic signed [SAMPLE_WIDTH_DEF-1:0] run_max;
	int                                 fill;

	// rescale every held sample of the closed block into the target range
	task automatic rescale_block();
		longint     lo;
		longint     hi;
		longint     span;
		longint     val;
		int         k;
		norm_beat_t nb;
		lo   = tgt_low;
		hi   = tgt_high;
		span = longint'(run_max) - longint'(run_min);
		if (span > 0 && lo == hi) begin
			lo = ZERO_Q88;
			hi = ONE_Q88;
		end
		for (k = 0; k < fill; k++) begin
			if (span <= 0)
				val = (lo + hi) >>> 1;
			else
				val = lo + ((longint'(held[k]) - longint'(run_min)) * (hi - lo)) / span;
			nb.value = val[DATA_W-1:0];
			nb.last  = (k == fill - 1);
			scaled_due.push_back(nb);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_low  = ZERO_Q88;
			tgt_high = ONE_Q88;
			run_min  = SAMPLE_MAX;
			run_max  = SAMPLE_MIN;
			fill     = 0;
			scaled_due.delete();
			pending  = 0;
		end else begin
			if (result_strobe) begin
				if (scaled_due.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected beat, expected none, got scaled %0d last_out %0b",
						$time, scaled, last_out);
				end else begin
					head = scaled_due.pop_front();
					if (scaled !== head.value) begin
						mismatches++;
						$display("%0t: scaled expected %0d got %0d",
							$time, $signed(head.value), scaled);
					end
					if (last_out !== head.last) begin
						mismatches++;
						$display("%0t: last_out expected %0b got %0b",
							$time, head.last, last_out);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_TARGET_LOW)
					tgt_low = cfg_data;
				else if (cfg_index == CFG_TARGET_HIGH)
					tgt_high = cfg_data;
			end
			if (start && !busy) begin
				if (fill >= DEPTH_DEF)
					fill = 0;
				held[fill] = sample;
				fill++;
				if (sample < run_min)
					run_min = sample;
				if (sample > run_max)
					run_max = sample;
				if (last_in || fill >= DEPTH_DEF) begin
					rescale_block();
					run_min = SAMPLE_MAX;
					run_max = SAMPLE_MIN;
					fill    = 0;
				end
			end
			pending = scaled_due.size();
		end
	end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// top-level bench for min_max_normalize: drives sample blocks and target settings,
// depends on mmn_pkg, min_max_normalize and mmn_checker
module tb;
	import mmn_pkg::*;

	logic                               clk = 1'b0;
	logic                               arst_n;
	logic                               start;
	logic                               busy;
	logic signed [SAMPLE_WIDTH_DEF-1:0] sample;
	logic                               last_in;
	logic                               result_strobe;
	logic signed [DATA_W-1:0]           scaled;
	logic                               last_out;
	logic                               cfg_valid;
	logic                               cfg_ready;
	logic [CFG_IDX_W-1:0]               cfg_index;
	logic [DATA_W-1:0]                  cfg_data;
	int                                 mismatches;
	int                                 pending;

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	min_max_normalize u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.sample        (sample),
		.last_in       (last_in),
		.result_strobe (result_strobe),
		.scaled        (scaled),
		.last_out      (last_out),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	mmn_checker u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.sample        (sample),
		.last_in       (last_in),
		.result_strobe (result_strobe),
		.scaled        (scaled),
		.last_out      (last_out),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	// all tasks are entered on a rising edge and return on one
	// busy and cfg_ready only move on rising edges, so the falling edge
	// shows what the next rising edge will see

	// present one sample beat and hold it until the block takes it;
	// start stays high on return so back-to-back beats need no re-assert
	task automatic push_sample(input logic signed [SAMPLE_WIDTH_DEF-1:0] s, input logic l);
		start   <= 1'b1;
		sample  <= s;
		last_in <= l;
		do @(negedge clk); while (busy);
		@(posedge clk);
	endtask

	// sender idles; junk on the payload to show it is ignored
	task automatic sender_gap(input int cycles);
		start   <= 1'b0;
		sample  <= SAMPLE_WIDTH_DEF'($urandom);
		last_in <= 1'($urandom);
		repeat (cycles) @(posedge clk);
	endtask

	// hold off until every predicted beat is out and the block has gone idle,
	// then wait on for the divider to wind down
	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (pending != 0 || busy);
		repeat (25) @(posedge clk);
	endtask

	// one config beat; cfg_valid is left high for a following write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
	endtask

	// only called with the block idle
	task automatic set_targets(input logic signed [DATA_W-1:0] lo,
		input logic signed [DATA_W-1:0] hi);
		write_reg(CFG_TARGET_LOW, lo);
		write_reg(CFG_TARGET_HIGH, hi);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int                                 sent;
		int                                 phase_sent;
		int                                 blocks;
		int                                 len;
		int                                 flavour;
		int                                 j;
		bit                                 quiet;
		bit                                 bursty;
		logic                               fin;
		logic signed [SAMPLE_WIDTH_DEF-1:0] base;
		logic signed [SAMPLE_WIDTH_DEF-1:0] val;
		logic signed [DATA_W-1:0]           lo;
		logic signed [DATA_W-1:0]           hi;

		arst_n    = 1'b0;
		start     = 1'b0;
		sample    = '0;
		last_in   = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_TARGET_LOW;
		cfg_data  = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, reset targets 0 .. 1.0 first
		// single-sample block: max equals min, midpoint of the targets
		push_sample(16'sh7FFF, 1'b1);
		// widest possible spread of samples
		push_sample(16'sh8000, 1'b0);
		push_sample(16'sh7FFF, 1'b1);
		push_sample(16'sd0, 1'b0);
		push_sample(16'sd100, 1'b0);
		push_sample(-16'sd100, 1'b1);
		drain();

		// widest target range, largest product the divider will see
		set_targets(16'sh8000, 16'sh7FFF);
		push_sample(16'sh8000, 1'b0);
		push_sample(16'sd0, 1'b0);
		push_sample(16'sh7FFF, 1'b0);
		push_sample(16'sd1, 1'b1);
		drain();

		// reversed targets, quotient truncated toward zero on a negative product
		set_targets(16'sh7FFF, 16'sh8000);
		push_sample(16'sd5, 1'b0);
		push_sample(-16'sd5, 1'b0);
		push_sample(16'sd1000, 1'b1);
		// flat block with an odd negative target sum: floor rounds down
		push_sample(16'sd7, 1'b0);
		push_sample(16'sd7, 1'b1);
		drain();

		// equal targets fall back to 0 .. 1.0, except for a flat block
		set_targets(-16'sd300, -16'sd300);
		push_sample(16'sd10, 1'b0);
		push_sample(16'sd20, 1'b0);
		push_sample(16'sd30, 1'b1);
		push_sample(16'sd3, 1'b0);
		push_sample(16'sd3, 1'b1);
		drain();

		// random part: phases of blocks, targets changed between phases
		sent   = 0;
		blocks = 0;
		while (sent < 350) begin
			case ($urandom_range(0, 5))
				0: begin
					lo = DATA_W'($urandom);
					hi = DATA_W'($urandom);
				end
				1: begin
					lo = 16'sh8000;
					hi = 16'sh7FFF;
				end
				2: begin
					lo = 16'sh7FFF;
					hi = 16'sh8000;
				end
				3: begin
					lo = DATA_W'($urandom);
					hi = lo;
				end
				4: begin
					lo = ZERO_Q88;
					hi = ONE_Q88;
				end
				default: begin
					lo = DATA_W'($urandom_range(0, 1023)) - 16'sd512;
					hi = lo + DATA_W'($urandom_range(0, 2047)) - 16'sd1024;
				end
			endcase
			set_targets(lo, hi);

			// the tail of the run goes back-to-back
			quiet      = (sent >= 290);
			phase_sent = 0;
			while (phase_sent < 45 && sent < 350) begin
				// first random block fills the store without a last flag
				if (blocks == 0)
					len = DEPTH_DEF;
				else if ($urandom_range(0, 9) == 0)
					len = DEPTH_DEF;
				else
					len = $urandom_range(1, 12);
				flavour = $urandom_range(0, 4);
				bursty  = !quiet && $urandom_range(0, 2) != 0;
				base    = SAMPLE_WIDTH_DEF'($urandom);
				for (j = 0; j < len; j++) begin
					case (flavour)
						0, 1: val = SAMPLE_WIDTH_DEF'($urandom);
						2: val = base + SAMPLE_WIDTH_DEF'($urandom_range(0, 15));
						3: val = base;
						default: val = SAMPLE_WIDTH_DEF'($urandom_range(0, 1024)) - 16'sd512;
					endcase
					if (j != len - 1)
						fin = 1'b0;
					else if (len == DEPTH_DEF)
						fin = (blocks == 0) ? 1'b0 : 1'($urandom);
					else
						fin = 1'b1;
					if (bursty && $urandom_range(0, 3) == 0)
						sender_gap($urandom_range(1, 15));
					push_sample(val, fin);
					sent++;
					phase_sent++;
				end
				blocks++;
				// now and then wait for the block's whole output before going on
				if (!quiet && $urandom_range(0, 7) == 0)
					drain();
			end
			drain();
		end

		if (mismatches == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
